>>> sv/cbor_header_decoder_defines.svh
// Assertion macros for the header decoder top level.
`ifndef CBOR_HEADER_DECODER_DEFINES_SVH
`define CBOR_HEADER_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that an antecedent implies a consequent on every clock.
`define CBOR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that a condition never holds.
`define CBOR_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define CBOR_ASSERT_IMPL(label, ante, cons, msg)
`define CBOR_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> sv/cbor_hdr_pkg.sv
// Types and constants for the CBOR item header decoder.
package cbor_hdr_pkg;

	// Parser phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_ARG    = 3'b010,
		PH_SKIP   = 3'b100
	} phase_t;

	// Major types with special handling
	localparam logic [2:0] TYPE_NEG   = 3'd1;
	localparam logic [2:0] TYPE_TEXT  = 3'd3;
	localparam logic [2:0] TYPE_ARRAY = 3'd4;
	localparam logic [2:0] TYPE_TAG   = 3'd6;

	// Additional info boundaries
	localparam logic [4:0] INFO_DIRECT_MAX = 5'd23;
	localparam logic [4:0] INFO_ARG_MAX    = 5'd27;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	// One decoded item
	typedef struct packed {
		logic [2:0]         major_type;
		logic signed [63:0] item_value;
		logic               has_tag;
		logic [7:0]         tag_value;
		logic [7:0]         header_bytes;
		logic               length_clamped;
	} result_t;

	// Handshake between parser and result register
	typedef struct packed {
		logic step;   // parser consumes the staged byte
		logic emit;   // staged byte completes an item
	} step_ctrl_t;

endpackage

>>> sv/cbor_hdr_parse.sv
// Header parser: state registers and the per-byte decode step.
module cbor_hdr_parse
	import cbor_hdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  logic [31:0] limit_in,
	output logic        emit,
	output result_t     result
);

	phase_t      phase_q, phase_nxt;
	logic [7:0]  rem_q, rem_nxt, rem_dec;
	logic [63:0] acc_q, acc_nxt, acc_or;
	logic [2:0]  idx_q, idx_nxt;
	logic [4:0]  info_q, info_nxt;
	logic [2:0]  type_q, type_nxt;
	logic        tag_seen_q, tag_seen_nxt;
	logic [7:0]  tag_q, tag_nxt;
	logic [7:0]  cnt_q, cnt_nxt, cnt_inc;
	logic        fin;
	logic [2:0]  fin_type;
	logic [63:0] fin_value;
	logic [63:0] out_value;
	logic        clamped;

	assign cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 8'd1;
	assign rem_dec = (rem_q != 8'd0) ? rem_q - 8'd1 : rem_q;
	assign acc_or  = acc_q | ({56'd0, byte_in} << {idx_q, 3'b000});

	// Decode one byte and work out the next state
	always_comb begin
		phase_nxt = phase_q;
		rem_nxt   = rem_q;
		acc_nxt   = acc_q;
		idx_nxt   = idx_q;
		info_nxt  = info_q;
		type_nxt  = type_q;
		fin       = 1'b0;
		fin_type  = type_q;
		fin_value = acc_or;
		case (phase_q)
			PH_ARG: begin
				rem_nxt = rem_dec;
				acc_nxt = acc_or;
				idx_nxt = idx_q + 3'd1;
				fin     = (rem_dec == 8'd0);
			end
			PH_SKIP: begin
				rem_nxt   = rem_dec;
				fin       = (rem_dec == 8'd0);
				fin_value = {59'd0, info_q};
			end
			default: begin
				type_nxt  = byte_in[7:5];
				info_nxt  = byte_in[4:0];
				fin_type  = byte_in[7:5];
				fin_value = {59'd0, byte_in[4:0]};
				acc_nxt   = '0;
				idx_nxt   = '0;
				if (byte_in[4:0] <= INFO_DIRECT_MAX) begin
					fin = 1'b1;
				end else if (byte_in[4:0] <= INFO_ARG_MAX) begin
					phase_nxt = PH_ARG;
					rem_nxt   = 8'd1 << byte_in[1:0];
				end else begin
					phase_nxt = PH_SKIP;
					rem_nxt   = 8'd16 << byte_in[1:0];
				end
			end
		endcase
		// Return to header phase on completion
		if (fin) begin
			phase_nxt = PH_HEADER;
			rem_nxt   = '0;
			acc_nxt   = '0;
			idx_nxt   = '0;
		end
	end

	// Form the result and update tag and byte count
	always_comb begin
		emit         = fin && (fin_type != TYPE_TAG);
		clamped      = 1'b0;
		out_value    = fin_value;
		tag_seen_nxt = tag_seen_q;
		tag_nxt      = tag_q;
		cnt_nxt      = cnt_inc;
		if (fin_type == TYPE_NEG) begin
			out_value = 64'd0 - fin_value;
		end else if ((fin_type == TYPE_ARRAY || fin_type == TYPE_TEXT)
				&& fin_value > {32'd0, limit_in}) begin
			out_value = {32'd0, limit_in};
			clamped   = 1'b1;
		end
		if (fin && fin_type == TYPE_TAG && !tag_seen_q) begin
			tag_seen_nxt = 1'b1;
			tag_nxt      = fin_value[7:0];
		end
		if (emit) begin
			tag_seen_nxt = 1'b0;
			tag_nxt      = '0;
			cnt_nxt      = '0;
		end
		result.major_type     = fin_type;
		result.item_value     = out_value;
		result.has_tag        = tag_seen_q;
		result.tag_value      = tag_seen_q ? tag_q : 8'd0;
		result.header_bytes   = cnt_inc;
		result.length_clamped = clamped;
	end

	// Advance parser state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			rem_q      <= '0;
			acc_q      <= '0;
			idx_q      <= '0;
			info_q     <= '0;
			type_q     <= '0;
			tag_seen_q <= 1'b0;
			tag_q      <= '0;
			cnt_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_nxt;
			rem_q      <= rem_nxt;
			acc_q      <= acc_nxt;
			idx_q      <= idx_nxt;
			info_q     <= info_nxt;
			type_q     <= type_nxt;
			tag_seen_q <= tag_seen_nxt;
			tag_q      <= tag_nxt;
			cnt_q      <= cnt_nxt;
		end
	end

endmodule

>>> sv/cbor_hdr_outreg.sv
// Result register that holds one decoded item until it is taken.
module cbor_hdr_outreg
	import cbor_hdr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  step_ctrl_t ctrl,
	input  result_t    result_in,
	input  logic       out_ready,
	output logic       out_free,
	output logic       out_valid,
	output result_t    result_out
);

	logic    valid_q;
	result_t res_q;
	logic    load;

	assign out_free  = !valid_q || out_ready;
	assign load      = ctrl.step && ctrl.emit;
	assign out_valid = valid_q;
	assign result_out = res_q;

	// Track valid: set on load, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result_in;
		end
	end

endmodule

>>> sv/cbor_header_decoder.sv
// Top level of the CBOR item header decoder.
//
// chan | handshake           | fields
// -----+---------------------+------------------------------------------------------------
// in   | in_valid/in_ready   | data_byte length_limit
// out  | out_valid/out_ready | major_type item_value has_tag tag_value header_bytes length_clamped
//
// One byte per cycle while the output is not stalled: a byte waits in the input
// register and the parser decodes it in one pass into the result register, so
// out_valid rises once the byte completing a header has passed both registers.
// Reset clears the parser to the header phase and empties both registers.
// A stalled output blocks only bytes that complete an item; other bytes
// keep flowing through the parser.
`include "cbor_header_decoder_defines.svh"

module cbor_header_decoder
	import cbor_hdr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic [31:0]        length_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         major_type,
	output logic signed [63:0] item_value,
	output logic               has_tag,
	output logic [7:0]         tag_value,
	output logic [7:0]         header_bytes,
	output logic               length_clamped
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [31:0] limit_s1;
	logic        emit;
	logic        out_free;
	logic        clamp_ok;
	step_ctrl_t  ctrl;
	result_t     parse_res;
	result_t     out_res;

	// Consume the staged byte when its result has room
	assign ctrl.emit = emit;
	assign ctrl.step = valid_s1 && (!emit || out_free);
	assign in_ready  = !valid_s1 || ctrl.step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			limit_s1 <= length_limit;
		end
	end

	cbor_hdr_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (ctrl.step),
		.byte_in  (byte_s1),
		.limit_in (limit_s1),
		.emit     (emit),
		.result   (parse_res)
	);

	cbor_hdr_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.result_in  (parse_res),
		.out_ready  (out_ready),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.result_out (out_res)
	);

	assign major_type     = out_res.major_type;
	assign item_value     = out_res.item_value;
	assign has_tag        = out_res.has_tag;
	assign tag_value      = out_res.tag_value;
	assign header_bytes   = out_res.header_bytes;
	assign length_clamped = out_res.length_clamped;

	// A clamped length is a text or array length that fits the 32-bit limit
	assign clamp_ok = (major_type == TYPE_TEXT || major_type == TYPE_ARRAY)
		&& item_value[63:32] == 32'd0;

	`CBOR_ASSERT_NEVER(a_no_tag_out, out_valid && major_type == TYPE_TAG, "tag header emitted as item")
	`CBOR_ASSERT_IMPL(a_count_nonzero, out_valid, header_bytes != 8'd0, "result with zero byte count")
	`CBOR_ASSERT_IMPL(a_tag_zero, out_valid && !has_tag, tag_value == 8'd0, "tag value without tag")
	`CBOR_ASSERT_IMPL(a_clamp_type, out_valid && length_clamped, clamp_ok, "bad clamped result")

endmodule
